// ----- rtl/bhc_pkg.sv -----
// Shared types, constants and angle-table function for the bearing and heading check.
// Depends on nothing; the other files in rtl, bhc_checker apart, use it by scoped names.
`default_nettype none

package bhc_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 24;

	localparam int COORD_W          = 32;
	localparam int DIFF_W           = 33;
	localparam int HEADING_W        = 10;
	localparam int BEARING_W        = 10;
	localparam int NORM_W           = 60;
	localparam int CORDIC_W         = 64;
	localparam int NORM_STAGES      = 6;
	localparam int CORDIC_EXTRA     = 8;
	localparam int CORDIC_MAX_ITERS = 62;
	localparam int DEG_INT_W        = 8;
	localparam int FLAG_DIFF_W      = 12;

	localparam int DEG_45  = 45;
	localparam int DEG_90  = 90;
	localparam int DEG_180 = 180;
	localparam int DEG_270 = 270;
	localparam int DEG_360 = 360;

	localparam logic signed [BEARING_W-1:0] BEARING_NONE    = -10'sd1;
	localparam logic signed [HEADING_W-1:0] HEADING_UNKNOWN = -10'sd1;

	localparam logic [63:0] PICO_PER_DEG = 64'd1000000000000;
	localparam logic [63:0] RAD_PICODEG  = 64'd57295779513082;

	// atan(2^-i) in units of 1e-12 degree
	localparam logic [63:0] ATAN_PICO [16] = '{
		64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
		64'd3576334374997,  64'd1789910608246,  64'd895173710211,   64'd447614170861,
		64'd223810500369,   64'd111905677066,   64'd55952891894,    64'd27976452617,
		64'd13988227142,    64'd6994113675,     64'd3497056851,     64'd1748528427
	};

	// how the angle of a point pair is found
	typedef enum logic [2:0] {
		KIND_SAME   = 3'd0,	// points coincide
		KIND_AXIS_N = 3'd1,	// on the north-south axis
		KIND_AXIS_E = 3'd2,	// on the east-west axis
		KIND_DIAG   = 3'd3,	// on a 45 degree diagonal
		KIND_CORDIC = 3'd4
	} kind_t;

	typedef struct packed {
		logic                          dx_neg;
		logic                          dy_neg;
		logic                          swap;
		kind_t                         kind;
		logic signed [HEADING_W-1:0]   heading;
	} side_t;

	// atan(2^-i) in degrees with frac fractional bits, truncated
	function automatic logic [63:0] atan_step(input int i, input int frac);
		logic [63:0] pd;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] res;
		int          b;
		if (i < 16) begin
			pd = ATAN_PICO[i[3:0]];
		end else begin
			pd = RAD_PICODEG >> i;
		end
		q   = pd / PICO_PER_DEG;
		r   = pd % PICO_PER_DEG;
		res = q << frac;
		for (b = frac - 1; b >= 0; b--) begin
			r = r << 1;
			if (r >= PICO_PER_DEG) begin
				r   = r - PICO_PER_DEG;
				res = res | (64'd1 << b);
			end
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/bhc_prep.sv -----
// Front end: coordinate differences, magnitudes and classification, two stages.
// Depends on bhc_pkg.
`default_nettype none

module bhc_prep (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire logic                                 valid,
	input  wire logic signed [bhc_pkg::COORD_W-1:0]   from_x,
	input  wire logic signed [bhc_pkg::COORD_W-1:0]   from_y,
	input  wire logic signed [bhc_pkg::COORD_W-1:0]   to_x,
	input  wire logic signed [bhc_pkg::COORD_W-1:0]   to_y,
	input  wire logic signed [bhc_pkg::HEADING_W-1:0] heading,
	output logic                                      valid_s2,
	output bhc_pkg::side_t                            side_s2,
	output logic [bhc_pkg::DIFF_W-1:0]                small_s2,
	output logic [bhc_pkg::DIFF_W-1:0]                big_s2
);

	logic [bhc_pkg::DIFF_W-1:0] dxp, dxn, dyp, dyn;

	logic                               valid_s1;
	logic [bhc_pkg::DIFF_W-1:0]         ax_s1, ay_s1;
	logic                               dx_neg_s1, dy_neg_s1;
	logic signed [bhc_pkg::HEADING_W-1:0] heading_s1;

	bhc_pkg::side_t               side_d;
	logic                         lt;

	// both directions of the subtraction, pick the non-negative one
	assign dxp = {to_x[bhc_pkg::COORD_W-1], to_x} - {from_x[bhc_pkg::COORD_W-1], from_x};
	assign dxn = {from_x[bhc_pkg::COORD_W-1], from_x} - {to_x[bhc_pkg::COORD_W-1], to_x};
	assign dyp = {to_y[bhc_pkg::COORD_W-1], to_y} - {from_y[bhc_pkg::COORD_W-1], from_y};
	assign dyn = {from_y[bhc_pkg::COORD_W-1], from_y} - {to_y[bhc_pkg::COORD_W-1], to_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1      <= dxp[bhc_pkg::DIFF_W-1] ? dxn : dxp;
			ay_s1      <= dyp[bhc_pkg::DIFF_W-1] ? dyn : dyp;
			dx_neg_s1  <= dxp[bhc_pkg::DIFF_W-1];
			dy_neg_s1  <= dyp[bhc_pkg::DIFF_W-1];
			heading_s1 <= heading;
		end
	end

	assign lt = ax_s1 < ay_s1;

	always_comb begin
		side_d.dx_neg  = dx_neg_s1;
		side_d.dy_neg  = dy_neg_s1;
		side_d.swap    = !lt;
		side_d.heading = heading_s1;
		if (ax_s1 == '0 && ay_s1 == '0) begin
			side_d.kind = bhc_pkg::KIND_SAME;
		end else if (ax_s1 == '0) begin
			side_d.kind = bhc_pkg::KIND_AXIS_N;
		end else if (ay_s1 == '0) begin
			side_d.kind = bhc_pkg::KIND_AXIS_E;
		end else if (ax_s1 == ay_s1) begin
			side_d.kind = bhc_pkg::KIND_DIAG;
		end else begin
			side_d.kind = bhc_pkg::KIND_CORDIC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2  <= side_d;
			small_s2 <= lt ? ax_s1 : ay_s1;
			big_s2   <= lt ? ay_s1 : ax_s1;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bhc_norm_cell.sv -----
// One normalizer cell: shifts the vector left by SHIFT when the top SHIFT bits are clear.
// Depends on bhc_pkg.
`default_nettype none

module bhc_norm_cell #(
	parameter int SHIFT = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          valid,
	input  wire bhc_pkg::side_t                side,
	input  wire logic [bhc_pkg::NORM_W-1:0]    minor,
	input  wire logic [bhc_pkg::NORM_W-1:0]    big,
	output logic                               valid_s1,
	output bhc_pkg::side_t                     side_s1,
	output logic [bhc_pkg::NORM_W-1:0]         small_s1,
	output logic [bhc_pkg::NORM_W-1:0]         big_s1
);

	logic hit;

	assign hit = (big[bhc_pkg::NORM_W-1 -: SHIFT] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1  <= side;
			small_s1 <= hit ? (minor << SHIFT) : minor;
			big_s1   <= hit ? (big << SHIFT) : big;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bhc_cordic_cell.sv -----
// One vectoring CORDIC cell: a single micro-rotation with its atan step as a constant.
// Depends on bhc_pkg.
`default_nettype none

module bhc_cordic_cell #(
	parameter int FRAC = bhc_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int STEP = 0
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic                                valid,
	input  wire bhc_pkg::side_t                      side,
	input  wire logic signed [bhc_pkg::CORDIC_W-1:0] x,
	input  wire logic signed [bhc_pkg::CORDIC_W-1:0] y,
	input  wire logic signed [FRAC+8:0]              z,
	output logic                                     valid_s1,
	output bhc_pkg::side_t                           side_s1,
	output logic signed [bhc_pkg::CORDIC_W-1:0]      x_s1,
	output logic signed [bhc_pkg::CORDIC_W-1:0]      y_s1,
	output logic signed [FRAC+8:0]                   z_s1
);

	localparam int          ZW     = FRAC + 9;
	localparam logic [63:0] ATAN64 = bhc_pkg::atan_step(STEP, FRAC);
	localparam logic signed [ZW-1:0] ATAN = $signed(ATAN64[ZW-1:0]);

	logic signed [bhc_pkg::CORDIC_W-1:0] xs, ys;
	logic                                up;

	assign xs = x >>> STEP;
	assign ys = y >>> STEP;
	assign up = !y[bhc_pkg::CORDIC_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	// rotate toward the x axis, accumulate the angle
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side;
			if (up) begin
				x_s1 <= x + ys;
				y_s1 <= y - xs;
				z_s1 <= z + ATAN;
			end else begin
				x_s1 <= x - ys;
				y_s1 <= y + xs;
				z_s1 <= z - ATAN;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bhc_post.sv -----
// Back end: clamp the CORDIC angle, fold it into a compass bearing, two stages.
// Depends on bhc_pkg.
`default_nettype none

module bhc_post #(
	parameter int FRAC = bhc_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     en,
	input  wire logic                                     valid,
	input  wire bhc_pkg::side_t                           side,
	input  wire logic signed [FRAC+8:0]                   z,
	output logic                                          valid_s2,
	output logic signed [bhc_pkg::BEARING_W-1:0]          bearing_s2,
	output logic signed [bhc_pkg::HEADING_W-1:0]          heading_s2
);

	localparam int ZW = FRAC + 9;
	localparam logic signed [ZW-1:0] Z45  = ZW'(bhc_pkg::DEG_45) <<< FRAC;
	localparam logic signed [ZW-1:0] Z90  = ZW'(bhc_pkg::DEG_90) <<< FRAC;
	localparam logic signed [ZW-1:0] Z180 = ZW'(bhc_pkg::DEG_180) <<< FRAC;

	logic signed [ZW-1:0] zc;
	logic                 swap_eff;
	bhc_pkg::side_t       side_d;

	logic                 valid_s1;
	bhc_pkg::side_t       side_s1;
	logic signed [ZW-1:0] zc_s1;

	logic signed [ZW-1:0]              base;
	logic signed [ZW-1:0]              mag;
	logic [bhc_pkg::DEG_INT_W-1:0]     m;
	logic signed [bhc_pkg::BEARING_W-1:0] deg;

	// exact angles for the axes and diagonals, clamp the rest to 0..45
	always_comb begin
		swap_eff = 1'b0;
		case (side.kind)
			bhc_pkg::KIND_AXIS_N: zc = '0;
			bhc_pkg::KIND_AXIS_E: zc = Z90;
			bhc_pkg::KIND_DIAG:   zc = Z45;
			bhc_pkg::KIND_CORDIC: begin
				swap_eff = side.swap;
				if (z < 0) begin
					zc = '0;
				end else if (z > Z45) begin
					zc = Z45;
				end else begin
					zc = z;
				end
			end
			default: zc = '0;
		endcase
		side_d      = side;
		side_d.swap = swap_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_d;
			zc_s1   <= zc;
		end
	end

	// magnitude of the signed angle: z, 90 - z, 90 + z or 180 - z
	always_comb begin
		if (side_s1.swap) begin
			base = Z90;
		end else if (side_s1.dy_neg) begin
			base = Z180;
		end else begin
			base = '0;
		end
		if (side_s1.swap != side_s1.dy_neg) begin
			mag = base - zc_s1;
		end else begin
			mag = base + zc_s1;
		end
		m = mag[FRAC +: bhc_pkg::DEG_INT_W];
		if (side_s1.kind == bhc_pkg::KIND_SAME) begin
			deg = bhc_pkg::BEARING_NONE;
		end else if (side_s1.dx_neg && m != '0) begin
			deg = bhc_pkg::BEARING_W'(bhc_pkg::DEG_360) - {2'b00, m};
		end else begin
			deg = {2'b00, m};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bearing_s2 <= deg;
			heading_s2 <= side_s1.heading;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bearing_and_heading_check_core.sv -----
// Top level of the bearing and heading check: prep, normalizer chain, CORDIC chain, back end.
// Depends on bhc_pkg, bhc_prep, bhc_norm_cell, bhc_cordic_cell and bhc_post.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one request: observer point from_x/from_y,
//    target point to_x/to_y and the current heading (-1 when unknown).
//  - Output channel (out_valid / out_stall) returns one result per request, in order:
//    bearing_deg (0..359, or -1 when the points coincide) and ahead_flag.
//  - From acceptance to out_valid a request passes the prep stages, the normalizer chain,
//    ITERS CORDIC cells, where ITERS is ANGLE_FRAC_BITS + 8 (capped at 62), the back end
//    and the output register; each CORDIC cell does one micro-rotation.
//  - Throughput is one request per cycle while out_stall stays low.
//  - When out_stall holds a result, the pipeline keeps running into a one-entry skid
//    register; once that is occupied, in_stall rises and every stage holds until the
//    waiting result is taken. in_stall is a register output.
//  - Reset (arst_n low) clears every valid bit, those of the output and skid registers
//    included; no clearing pass, the block accepts a request as soon as reset is released.
//  - The axis directions and the 45 degree diagonals bypass the CORDIC angle and are exact.
`default_nettype none

module bearing_and_heading_check_core #(
	parameter int ANGLE_FRAC_BITS = bhc_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [bhc_pkg::COORD_W-1:0]    from_x,
	input  wire logic signed [bhc_pkg::COORD_W-1:0]    from_y,
	input  wire logic signed [bhc_pkg::COORD_W-1:0]    to_x,
	input  wire logic signed [bhc_pkg::COORD_W-1:0]    to_y,
	input  wire logic signed [bhc_pkg::HEADING_W-1:0]  heading,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [bhc_pkg::BEARING_W-1:0]       bearing_deg,
	output logic                                       ahead_flag
);

	localparam int ZW    = ANGLE_FRAC_BITS + 9;
	localparam int ITERS =
		(ANGLE_FRAC_BITS + bhc_pkg::CORDIC_EXTRA < bhc_pkg::CORDIC_MAX_ITERS) ?
		ANGLE_FRAC_BITS + bhc_pkg::CORDIC_EXTRA : bhc_pkg::CORDIC_MAX_ITERS;
	localparam int NS    = bhc_pkg::NORM_STAGES;
	localparam int NW    = bhc_pkg::NORM_W;
	localparam int CW    = bhc_pkg::CORDIC_W;
	localparam int FW    = bhc_pkg::FLAG_DIFF_W;

	// global advance: every stage moves unless the skid register is occupied
	logic en;

	logic                          prep_valid;
	bhc_pkg::side_t                prep_side;
	logic [bhc_pkg::DIFF_W-1:0]    prep_small, prep_big;

	logic                          nv     [0:NS];
	bhc_pkg::side_t                nside  [0:NS];
	logic [NW-1:0]                 nsmall [0:NS];
	logic [NW-1:0]                 nbig   [0:NS];

	logic                          cv     [0:ITERS];
	bhc_pkg::side_t                cside  [0:ITERS];
	logic signed [CW-1:0]          cx     [0:ITERS];
	logic signed [CW-1:0]          cy     [0:ITERS];
	logic signed [ZW-1:0]          cz     [0:ITERS];

	logic                                  fin_valid;
	logic signed [bhc_pkg::BEARING_W-1:0]  fin_bearing;
	logic signed [bhc_pkg::HEADING_W-1:0]  fin_heading;
	logic signed [FW-1:0]                  diff_raw, diff;
	logic                                  fin_flag;

	logic                                  out_valid_q;
	logic signed [bhc_pkg::BEARING_W-1:0]  out_bearing_q;
	logic                                  out_flag_q;
	logic                                  skid_valid_q;
	logic signed [bhc_pkg::BEARING_W-1:0]  skid_bearing_q;
	logic                                  skid_flag_q;
	logic                                  take;

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	bhc_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (in_valid),
		.from_x   (from_x),
		.from_y   (from_y),
		.to_x     (to_x),
		.to_y     (to_y),
		.heading  (heading),
		.valid_s2 (prep_valid),
		.side_s2  (prep_side),
		.small_s2 (prep_small),
		.big_s2   (prep_big)
	);

	// widen to the normalizer window
	assign nv[0]     = prep_valid;
	assign nside[0]  = prep_side;
	assign nsmall[0] = {{(NW - bhc_pkg::DIFF_W){1'b0}}, prep_small};
	assign nbig[0]   = {{(NW - bhc_pkg::DIFF_W){1'b0}}, prep_big};

	// leading-zero normalization, largest shift first
	for (genvar k = 0; k < NS; k++) begin : g_norm
		bhc_norm_cell #(
			.SHIFT (1 << (NS - 1 - k))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid    (nv[k]),
			.side     (nside[k]),
			.minor    (nsmall[k]),
			.big      (nbig[k]),
			.valid_s1 (nv[k+1]),
			.side_s1  (nside[k+1]),
			.small_s1 (nsmall[k+1]),
			.big_s1   (nbig[k+1])
		);
	end

	// start the rotation with the larger component on x, zero angle
	assign cv[0]    = nv[NS];
	assign cside[0] = nside[NS];
	assign cx[0]    = $signed({{(CW - NW){1'b0}}, nbig[NS]});
	assign cy[0]    = $signed({{(CW - NW){1'b0}}, nsmall[NS]});
	assign cz[0]    = '0;

	for (genvar i = 0; i < ITERS; i++) begin : g_cordic
		bhc_cordic_cell #(
			.FRAC (ANGLE_FRAC_BITS),
			.STEP (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid    (cv[i]),
			.side     (cside[i]),
			.x        (cx[i]),
			.y        (cy[i]),
			.z        (cz[i]),
			.valid_s1 (cv[i+1]),
			.side_s1  (cside[i+1]),
			.x_s1     (cx[i+1]),
			.y_s1     (cy[i+1]),
			.z_s1     (cz[i+1])
		);
	end

	bhc_post #(
		.FRAC (ANGLE_FRAC_BITS)
	) u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid      (cv[ITERS]),
		.side       (cside[ITERS]),
		.z          (cz[ITERS]),
		.valid_s2   (fin_valid),
		.bearing_s2 (fin_bearing),
		.heading_s2 (fin_heading)
	);

	// heading check: wrap the difference once; a difference still negative counts as ahead
	always_comb begin
		diff_raw = {{(FW - bhc_pkg::BEARING_W){fin_bearing[bhc_pkg::BEARING_W-1]}}, fin_bearing}
			- {{(FW - bhc_pkg::HEADING_W){fin_heading[bhc_pkg::HEADING_W-1]}}, fin_heading};
		if (diff_raw < 0) begin
			diff = diff_raw + FW'(bhc_pkg::DEG_360);
		end else begin
			diff = diff_raw;
		end
		fin_flag = (fin_heading == bhc_pkg::HEADING_UNKNOWN)
			|| (diff <= $signed(FW'(bhc_pkg::DEG_90)))
			|| (diff >= $signed(FW'(bhc_pkg::DEG_270)));
	end

	assign take = out_valid_q && !out_stall;

	// output register plus one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (fin_valid) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_bearing_q <= skid_bearing_q;
				out_flag_q    <= skid_flag_q;
			end
		end else if (fin_valid) begin
			if (!out_valid_q || take) begin
				out_bearing_q <= fin_bearing;
				out_flag_q    <= fin_flag;
			end else begin
				skid_bearing_q <= fin_bearing;
				skid_flag_q    <= fin_flag;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign bearing_deg = out_bearing_q;
	assign ahead_flag  = out_flag_q;

endmodule

`default_nettype wire

// ----- rtl/bhc_checker.sv -----
// Port-level checks for the bearing and heading check, bound to the top level.
// Depends on bearing_and_heading_check_core (bind target) only.
`default_nettype none

module bhc_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_stall,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic signed [9:0] bearing_deg,
	input  wire logic              ahead_flag
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(bearing_deg) && $stable(ahead_flag))
		else $error("result changed while stalled");

	// bearing is a compass angle or the coincident marker
	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bearing_deg == 10'h3FF) || (bearing_deg < 10'd360))
		else $error("bearing out of range");

	// backpressure only while a result waits
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// draining the waiting result releases the input at once
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |=> !in_stall)
		else $error("input still stalled after result taken");

	// no request is accepted while the output is still stalled and the skid is full
	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && out_stall |=> in_stall && out_valid)
		else $error("input stall dropped while output still stalled");

endmodule

bind bearing_and_heading_check_core bhc_checker u_bhc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.bearing_deg (bearing_deg),
	.ahead_flag  (ahead_flag)
);

`default_nettype wire

// ----- verif/bearing_check_tb_pkg.sv -----
`timescale 1ns / 1ps
// Bearing predictor and result scoreboard for the bearing and heading check testbench.
// Depends on bhc_pkg for widths and angle constants; holds no state besides the queue and mismatch count.

package bearing_check_tb_pkg;

	localparam int ANGLE_FRAC    = bhc_pkg::ANGLE_FRAC_BITS_DEF;
	localparam int CORDIC_STEPS  = (ANGLE_FRAC + 8 > 62) ? 62 : ANGLE_FRAC + 8;

	localparam logic [127:0] PICODEG_PER_DEG = 128'd1000000000000;
	localparam logic [127:0] PICODEG_PER_RAD = 128'd57295779513082;

	// atan(2^-i) in 1e-12 degree, i = 0..15
	localparam logic [127:0] MICRO_ANGLE_PICO [16] = '{
		128'd45000000000000, 128'd26565051177078, 128'd14036243467926, 128'd7125016348902,
		128'd3576334374997,  128'd1789910608246,  128'd895173710211,   128'd447614170861,
		128'd223810500369,   128'd111905677066,   128'd55952891894,    128'd27976452617,
		128'd13988227142,    128'd6994113675,     128'd3497056851,     128'd1748528427
	};

	typedef struct packed {
		logic signed [bhc_pkg::BEARING_W-1:0] bearing;
		logic                                 ahead;
	} bearing_result_t;

	// atan(2^-i) in fixed-point degrees, truncated
	function automatic longint micro_angle(input int i);
		logic [127:0] pico;
		logic [127:0] scaled;
		pico   = (i < 16) ? MICRO_ANGLE_PICO[i] : (PICODEG_PER_RAD >> i);
		scaled = (pico << ANGLE_FRAC) / PICODEG_PER_DEG;
		return longint'(scaled[63:0]);
	endfunction

	// atan(minor / major) in fixed-point degrees, 0 < minor < major
	function automatic longint cordic_angle_deg(input longint unsigned minor,
			input longint unsigned major);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		int     i;
		while (major < 64'h0800_0000_0000_0000) begin
			major = major << 1;
			minor = minor << 1;
		end
		x = longint'(major);
		y = longint'(minor);
		z = 0;
		for (i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + micro_angle(i);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - micro_angle(i);
			end
		end
		if (z < 0)
			z = 0;
		if (z > (longint'(bhc_pkg::DEG_45) << ANGLE_FRAC))
			z = longint'(bhc_pkg::DEG_45) << ANGLE_FRAC;
		return z;
	endfunction

	function automatic bearing_result_t predict_bearing(
			input logic signed [31:0] fx, input logic signed [31:0] fy,
			input logic signed [31:0] tx, input logic signed [31:0] ty,
			input logic signed [bhc_pkg::HEADING_W-1:0] hd);
		bearing_result_t  r;
		longint           dx;
		longint           dy;
		longint           phi;
		longint           a;
		longint unsigned  ax;
		longint unsigned  ay;
		int               deg;
		int               diff;
		dx = longint'(tx) - longint'(fx);
		dy = longint'(ty) - longint'(fy);
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		if (ax == 0 && ay == 0) begin
			deg = int'(bhc_pkg::BEARING_NONE);
		end else begin
			if (ax == 0)
				phi = 0;
			else if (ay == 0)
				phi = longint'(bhc_pkg::DEG_90) << ANGLE_FRAC;
			else if (ax == ay)
				phi = longint'(bhc_pkg::DEG_45) << ANGLE_FRAC;
			else if (ax < ay)
				phi = cordic_angle_deg(ax, ay);
			else
				phi = (longint'(bhc_pkg::DEG_90) << ANGLE_FRAC) - cordic_angle_deg(ay, ax);
			a = (dy >= 0) ? phi : (longint'(bhc_pkg::DEG_180) << ANGLE_FRAC) - phi;
			if (dx < 0)
				a = -a;
			deg = (a >= 0) ? int'(a >>> ANGLE_FRAC) : -int'((-a) >>> ANGLE_FRAC);
			if (deg < 0)
				deg = deg + bhc_pkg::DEG_360;
		end
		r.bearing = deg[bhc_pkg::BEARING_W-1:0];
		if (hd == bhc_pkg::HEADING_UNKNOWN) begin
			r.ahead = 1'b1;
		end else begin
			diff = deg - int'(hd);
			if (diff < 0)
				diff = diff + bhc_pkg::DEG_360;
			r.ahead = (diff <= bhc_pkg::DEG_90 || diff >= bhc_pkg::DEG_270);
		end
		return r;
	endfunction

	class bearing_scoreboard;
		bearing_result_t due_bearings[$];
		int              mismatches;

		function void note_request(input logic signed [31:0] fx, input logic signed [31:0] fy,
				input logic signed [31:0] tx, input logic signed [31:0] ty,
				input logic signed [bhc_pkg::HEADING_W-1:0] hd);
			due_bearings.push_back(predict_bearing(fx, fy, tx, ty, hd));
		endfunction

		function void check_result(input logic signed [bhc_pkg::BEARING_W-1:0] bearing,
				input logic ahead);
			bearing_result_t want;
			if (due_bearings.size() == 0) begin
				$display("%0t: result with nothing due: bearing %0d flag %0b",
					$time, bearing, ahead);
				mismatches++;
				return;
			end
			want = due_bearings.pop_front();
			if (bearing !== want.bearing) begin
				$display("%0t: bearing_deg expected %0d actual %0d",
					$time, want.bearing, bearing);
				mismatches++;
			end
			if (ahead !== want.ahead) begin
				$display("%0t: ahead_flag expected %0b actual %0b (bearing %0d)",
					$time, want.ahead, ahead, want.bearing);
				mismatches++;
			end
		endfunction

		function int due_count();
			return due_bearings.size();
		endfunction
	endclass

endpackage

// ----- verif/bearing_and_heading_check_core_tb.sv -----
`timescale 1ns / 1ps
// Top of the bearing and heading check testbench: clock, reset, request and result drivers.
// Depends on bhc_pkg, bearing_check_tb_pkg and the bearing_and_heading_check_core RTL.

module bearing_and_heading_check_core_tb;

	localparam int RANDOM_REQUESTS = 850;
	localparam int CALM_REQUESTS   = 120;	// tail of the run with no idling
	localparam int SQUEEZE_AT      = 300;	// sent count that starts the long output hold
	localparam int SQUEEZE_END     = 420;	// sender keeps offering up to here
	localparam int SQUEEZE_CYCLES  = 200;
	localparam int DRAIN_AT        = 550;	// random request index where the sender drains
	localparam int SETTLE_CYCLES   = 64;	// wait after the drain so a stray result shows up
	localparam int QUIET_LIMIT     = 5000;

	localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] EDGE_VALS [5] = '{C_MIN, C_MAX, 32'sd0, -32'sd1, 32'sd1};

	logic                                        clk;
	logic                                        arst_n;
	logic                                        in_valid;
	logic                                        in_stall;
	logic signed [bhc_pkg::COORD_W-1:0]          from_x;
	logic signed [bhc_pkg::COORD_W-1:0]          from_y;
	logic signed [bhc_pkg::COORD_W-1:0]          to_x;
	logic signed [bhc_pkg::COORD_W-1:0]          to_y;
	logic signed [bhc_pkg::HEADING_W-1:0]        heading;
	logic                                        out_valid;
	logic                                        out_stall;
	logic signed [bhc_pkg::BEARING_W-1:0]        bearing_deg;
	logic                                        ahead_flag;

	bearing_check_tb_pkg::bearing_scoreboard sb;
	int                sent_count;
	bit                calm;

	bearing_and_heading_check_core #(
		.ANGLE_FRAC_BITS(bearing_check_tb_pkg::ANGLE_FRAC)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.from_x     (from_x),
		.from_y     (from_y),
		.to_x       (to_x),
		.to_y       (to_y),
		.heading    (heading),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.bearing_deg(bearing_deg),
		.ahead_flag (ahead_flag)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Offer one request from a falling edge and hold it until the block takes it.
	// Returns at the next falling edge with in_valid still high.
	task automatic send_request(input logic signed [31:0] fx, input logic signed [31:0] fy,
			input logic signed [31:0] tx, input logic signed [31:0] ty,
			input logic signed [bhc_pkg::HEADING_W-1:0] hd);
		from_x   <= fx;
		from_y   <= fy;
		to_x     <= tx;
		to_y     <= ty;
		heading  <= hd;
		in_valid <= 1'b1;
		@(posedge clk);
		// in_stall is read before this edge's updates land, so this is the handshake value
		while (in_stall)
			@(posedge clk);
		sb.note_request(fx, fy, tx, ty, hd);
		sent_count++;
		@(negedge clk);
	endtask

	// Drop valid for a burst of cycles; starts and ends on a falling edge.
	task automatic idle_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles)
			@(negedge clk);
	endtask

	// Check every result the block hands over.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(bearing_deg, ahead_flag);
	end

	// Receiver: random stall bursts, one long hold once the sender is well under way,
	// and no stalls at all in the calm tail.
	initial begin
		bit squeezed;
		int burst;
		squeezed  = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!squeezed && sent_count >= SQUEEZE_AT) begin
				// hold off long enough to fill the pipeline and the skid register
				squeezed = 1'b1;
				out_stall <= 1'b1;
				repeat (SQUEEZE_CYCLES - 1)
					@(negedge clk);
			end else if (calm) begin
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, 18);
				out_stall <= 1'b1;
				repeat (burst - 1)
					@(negedge clk);
			end else begin
				burst = $urandom_range(1, 40);
				out_stall <= 1'b0;
				repeat (burst - 1)
					@(negedge clk);
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no handshake for %0d cycles at %0t", QUIET_LIMIT, $time);
		$display("status: fail");
		$finish;
	end

	// Stimulus: reset, directed requests, then random requests.
	initial begin
		logic signed [31:0]                   fx;
		logic signed [31:0]                   fy;
		logic signed [31:0]                   tx;
		logic signed [31:0]                   ty;
		logic signed [31:0]                   k;
		logic signed [bhc_pkg::HEADING_W-1:0] hd;
		int                                   n;
		int                                   sx;
		int                                   sy;
		sb         = new();
		sent_count = 0;
		calm       = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		from_x     = '0;
		from_y     = '0;
		to_x       = '0;
		to_y       = '0;
		heading    = '0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// coincident points, with unknown and known headings
		send_request(0, 0, 0, 0, bhc_pkg::HEADING_UNKNOWN);
		send_request(5, 5, 5, 5, 10);
		send_request(5, 5, 5, 5, 200);
		// the four axes, due south included
		send_request(0, 0, 0, 100, 0);
		send_request(0, 0, 0, -100, 0);
		send_request(0, 0, 100, 0, 359);
		send_request(0, 0, -100, 0, 90);
		// the four diagonals
		send_request(0, 0, 7, 7, 135);
		send_request(0, 0, 7, -7, 45);
		send_request(0, 0, -7, -7, 315);
		send_request(0, 0, -7, 7, 225);
		// largest differences, most headings outside 0..359
		send_request(C_MIN, C_MIN, C_MAX, C_MAX, 0);
		send_request(C_MAX, C_MAX, C_MIN, C_MIN, 511);
		send_request(C_MIN, 0, C_MAX, 1, -512);
		send_request(0, C_MIN, 1, C_MAX, -2);
		send_request(C_MAX, 0, C_MIN, -1, 400);
		// near the axes and on the flag boundaries
		send_request(0, 0, 1, C_MAX, 0);
		send_request(0, 0, C_MAX, -1, 180);
		send_request(-3, 10, 4, -20, 90);
		send_request(100, 100, 130, 152, 60);
		send_request(0, 0, 1000, 1, 0);
		send_request(0, 0, 1, -1000, 270);
		send_request(0, 0, -1, 1000, 90);

		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n >= RANDOM_REQUESTS - CALM_REQUESTS)
				calm = 1'b1;
			if (n == DRAIN_AT) begin
				// pause until every outstanding result is back
				in_valid <= 1'b0;
				@(negedge clk);
				while (sb.due_count() != 0)
					@(negedge clk);
			end else if (!calm && (sent_count < SQUEEZE_AT || sent_count > SQUEEZE_END)
					&& $urandom_range(0, 3) == 0) begin
				idle_sender($urandom_range(1, 18));
			end

			case ($urandom_range(0, 9))
				0, 1, 2: begin
					fx = $urandom;
					fy = $urandom;
					tx = $urandom;
					ty = $urandom;
				end
				3, 4: begin
					// short hops: axes, diagonals and coincidence come often
					fx = $signed($urandom) >>> 2;
					fy = $signed($urandom) >>> 2;
					tx = fx + (int'($urandom_range(0, 32)) - 16);
					ty = fy + (int'($urandom_range(0, 32)) - 16);
				end
				5: begin
					// exact axis or diagonal at any scale
					fx = $signed($urandom) >>> 2;
					fy = $signed($urandom) >>> 2;
					k  = $urandom_range(1, 32'h3FFF_FFFF);
					sx = int'($urandom_range(0, 2)) - 1;
					sy = int'($urandom_range(0, 2)) - 1;
					tx = fx + sx * k;
					ty = fy + sy * k;
				end
				6: begin
					// almost north or south
					fx = $urandom;
					fy = $urandom;
					tx = fx + (int'($urandom_range(0, 6)) - 3);
					ty = $urandom;
				end
				7: begin
					// almost east or west
					fx = $urandom;
					fy = $urandom;
					tx = $urandom;
					ty = fy + (int'($urandom_range(0, 6)) - 3);
				end
				8: begin
					fx = EDGE_VALS[$urandom_range(0, 4)];
					fy = EDGE_VALS[$urandom_range(0, 4)];
					tx = EDGE_VALS[$urandom_range(0, 4)];
					ty = EDGE_VALS[$urandom_range(0, 4)];
				end
				default: begin
					// mixed magnitudes
					fx = $signed($urandom) >>> $urandom_range(0, 31);
					fy = $signed($urandom) >>> $urandom_range(0, 31);
					tx = $signed($urandom) >>> $urandom_range(0, 31);
					ty = $signed($urandom) >>> $urandom_range(0, 31);
				end
			endcase
			if ($urandom_range(0, 4) == 0)
				hd = bhc_pkg::HEADING_W'($urandom_range(0, 1023));
			else
				hd = bhc_pkg::HEADING_W'(int'($urandom_range(0, 360)) - 1);
			send_request(fx, fy, tx, ty, hd);
		end
		in_valid <= 1'b0;

		// drain, then let the pipeline settle so any stray result shows up
		while (sb.due_count() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (sb.mismatches == 0 && sb.due_count() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
